// ----- rtl/apr_pkg.sv -----
// Package: beat types, scan state and ARM64 encoding constants for the address resolver.
`timescale 1ns / 1ps

package apr_pkg;

    localparam int unsigned REG_W  = 5;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned ADDR_W = 64;

    localparam logic [WORD_W-1:0] ADR_CLASS_MASK = 32'h9F00_0000;
    localparam logic [WORD_W-1:0] ADRP_CODE      = 32'h9000_0000;
    localparam logic [WORD_W-1:0] ADR_CODE       = 32'h1000_0000;
    localparam logic [WORD_W-1:0] ADD_MASK       = 32'hFF80_0000;
    localparam logic [WORD_W-1:0] ADD_CODE       = 32'h9100_0000;
    localparam logic [ADDR_W-1:0] PAGE_MASK      = 64'h0000_0000_0000_0FFF;

    localparam logic [REG_W-1:0] TARGET_RESET = '0;

    typedef struct packed {
        logic [WORD_W-1:0] instruction_word;
        logic [ADDR_W-1:0] instruction_address;
        logic              last_word;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] resolved_address;
        logic              found;
    } result_t;

    typedef struct packed {
        logic              page_pending;
        logic [ADDR_W-1:0] pending_page_base;
        logic              already_reported;
    } scan_state_t;

    localparam scan_state_t SCAN_CLEAR = '{page_pending: 1'b0,
                                           pending_page_base: '0,
                                           already_reported: 1'b0};

    // immhi:immlo of ADR/ADRP, sign-extended to 64 bits
    function automatic logic [ADDR_W-1:0] imm21_sext(input logic [WORD_W-1:0] w);
        logic [20:0] imm;
        imm = {w[23:5], w[30:29]};
        return {{(ADDR_W-21){imm[20]}}, imm};
    endfunction

endpackage

// ----- rtl/arm64_pc_relative_address_resolver_unit.sv -----
// Top level: input register, resolve logic, scan state and result register.
//
//  channel  signals                        beat
//  item     item_valid / item_ready        item_t: word, address, last flag
//  result   result_valid / result_ready    result_t: resolved address, found
//  cfg      cfg_valid / cfg_ready          cfg_data: target register number
//
// One item per cycle while the result register is not stalled; an item passes the
// input register and then the result register before its result beat is valid. The
// rate is set by the combinational decode and 64-bit adds between those two registers.
// Items with no result drain even while the result register is stalled.
// Reset clears the scan state and sets the target register to 0; cfg_ready is
// always high.
`timescale 1ns / 1ps

module arm64_pc_relative_address_resolver_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  apr_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output apr_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [apr_pkg::REG_W-1:0]     cfg_data
);
    import apr_pkg::*;

    logic [REG_W-1:0] target_reg;
    logic             stage_valid_reg;
    item_t            stage_reg;
    scan_state_t      state_reg;
    scan_state_t      state_next;
    logic             result_valid_reg;
    result_t          result_reg;
    logic             produce;
    result_t          result_next;
    logic             out_free;
    logic             stage_adv;

    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || result_ready;
    assign stage_adv    = stage_valid_reg && (!produce || out_free);
    assign item_ready   = !stage_valid_reg || stage_adv;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    apr_resolve u_resolve
    (
        .item            (stage_reg),
        .target_register (target_reg),
        .state           (state_reg),
        .produce         (produce),
        .result          (result_next),
        .state_next      (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_CLEAR;
        end
        else if (stage_adv)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= stage_adv && produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv && produce)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- rtl/apr_resolve.sv -----
// Decode of one instruction beat against the scan state: result and next state.
`timescale 1ns / 1ps

module apr_resolve
(
    input  apr_pkg::item_t                    item,
    input  logic [apr_pkg::REG_W-1:0]         target_register,
    input  apr_pkg::scan_state_t              state,
    output logic                              produce,
    output apr_pkg::result_t                  result,
    output apr_pkg::scan_state_t              state_next
);
    import apr_pkg::*;

    logic [WORD_W-1:0] w;
    logic              is_write;
    logic              add_hit;
    logic              is_adrp;
    logic              is_adr;
    logic              adr_hit;
    logic              hit;
    logic [ADDR_W-1:0] adr_off;
    logic [ADDR_W-1:0] add_imm;
    logic [ADDR_W-1:0] add_addr;
    logic [ADDR_W-1:0] adr_addr;
    logic [ADDR_W-1:0] adrp_page;

    assign w        = item.instruction_word;
    assign is_write = !state.already_reported && (w[REG_W-1:0] == target_register);
    assign is_adrp  = (w & ADR_CLASS_MASK) == ADRP_CODE;
    assign is_adr   = (w & ADR_CLASS_MASK) == ADR_CODE;
    assign add_hit  = is_write && state.page_pending && ((w & ADD_MASK) == ADD_CODE)
                      && (w[2*REG_W-1:REG_W] == target_register);
    assign adr_hit  = is_write && !add_hit && is_adr;
    assign hit      = add_hit || adr_hit;

    assign adr_off   = imm21_sext(w);
    assign add_imm   = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
    assign add_addr  = state.pending_page_base + add_imm;
    assign adr_addr  = item.instruction_address + adr_off;
    assign adrp_page = (item.instruction_address & ~PAGE_MASK)
                       + {adr_off[ADDR_W-13:0], 12'd0};

    assign produce = hit || (item.last_word && !state.already_reported);

    always_comb
    begin
        result.found            = hit;
        result.resolved_address = add_hit ? add_addr : (adr_hit ? adr_addr : '0);
    end

    always_comb
    begin
        state_next = state;
        if (is_write && !add_hit)
        begin
            state_next.page_pending = is_adrp;
            if (is_adrp)
            begin
                state_next.pending_page_base = adrp_page;
            end
        end
        if (hit)
        begin
            state_next.already_reported = 1'b1;
        end
        if (item.last_word)
        begin
            state_next = SCAN_CLEAR;
        end
    end

endmodule

// ----- rtl/apr_checker.sv -----
// Port checker for the address resolver, bound to the top level.
`timescale 1ns / 1ps

module apr_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_ready,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  apr_pkg::result_t              result,
    input  logic                          cfg_ready
);
    import apr_pkg::*;

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.resolved_address == '0)
        else $error("no-match result carries a nonzero address");

    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("item side stalled with empty result register");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg port not ready");

endmodule

bind arm64_pc_relative_address_resolver_unit apr_checker u_apr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_ready    (cfg_ready)
);

// ----- tb/resolved_address_check.sv -----
// Channel monitor and scan predictor for the PC-relative address resolver.
`timescale 1ns / 1ps

module resolved_address_check
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  logic                      item_ready,
    input  apr_pkg::item_t            item,
    input  logic                      result_valid,
    input  logic                      result_ready,
    input  apr_pkg::result_t          result,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [apr_pkg::REG_W-1:0] cfg_data,
    output int unsigned               mismatch_count,
    output int unsigned               awaited_count
);

    import apr_pkg::*;

    logic [REG_W-1:0]  target_reg = TARGET_RESET;
    logic              page_armed = 1'b0;
    logic [ADDR_W-1:0] page_base  = '0;
    logic              reported   = 1'b0;
    result_t           pending_results[$];

    // immhi:immlo, sign-extended
    function automatic logic [ADDR_W-1:0] adr_offset(input logic [WORD_W-1:0] w);
        logic signed [20:0] imm;
        logic signed [ADDR_W-1:0] wide;
        imm  = {w[23:5], w[30:29]};
        wide = imm;
        return wide;
    endfunction

    task automatic scan_word(input item_t it);
        logic [WORD_W-1:0] w;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] imm;
        result_t           r;
        w    = it.instruction_word;
        hit  = 1'b0;
        addr = '0;
        if (!reported && w[4:0] == target_reg)
        begin
            if (page_armed && (w & ADD_MASK) == ADD_CODE && w[9:5] == target_reg)
            begin
                imm = ADDR_W'(w[21:10]);
                if (w[22])
                    imm = imm << 12;
                addr = page_base + imm;
                hit  = 1'b1;
            end
            else
            begin
                page_armed = 1'b0;
                if ((w & ADR_CLASS_MASK) == ADRP_CODE)
                begin
                    page_base  = (it.instruction_address & ~PAGE_MASK) + (adr_offset(w) << 12);
                    page_armed = 1'b1;
                end
                else if ((w & ADR_CLASS_MASK) == ADR_CODE)
                begin
                    addr = it.instruction_address + adr_offset(w);
                    hit  = 1'b1;
                end
            end
        end
        if (hit)
        begin
            reported           = 1'b1;
            r.resolved_address = addr;
            r.found            = 1'b1;
            pending_results    = {pending_results, r};
        end
        else if (it.last_word && !reported)
        begin
            r = '0;
            pending_results = {pending_results, r};
        end
        if (it.last_word)
        begin
            page_armed = 1'b0;
            page_base  = '0;
            reported   = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            target_reg = TARGET_RESET;
            page_armed = 1'b0;
            page_base  = '0;
            reported   = 1'b0;
            pending_results.delete();
            mismatch_count = 0;
            awaited_count  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                target_reg = cfg_data;
            // a result beat never belongs to an item accepted at the same edge
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing pending: resolved_address %h found %b",
                           result.resolved_address, result.found);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.resolved_address !== want.resolved_address)
                    begin
                        $error("resolved_address: expected %h, actual %h",
                               want.resolved_address, result.resolved_address);
                        mismatch_count++;
                    end
                    if (result.found !== want.found)
                    begin
                        $error("found: expected %b, actual %b", want.found, result.found);
                        mismatch_count++;
                    end
                end
            end
            if (item_valid && item_ready)
                scan_word(item);
            awaited_count = pending_results.size();
        end
    end

endmodule

// ----- tb/arm64_pc_relative_address_resolver_unit_test.sv -----
// Testbench top: stimulus, result sink, watchdog and verdict for the address resolver.
`timescale 1ns / 1ps

module arm64_pc_relative_address_resolver_unit_test;

    import apr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 130;
    localparam int PHASE_COUNT  = 6;

    typedef enum int {SEQ_PAIR, SEQ_ADR, SEQ_CANCEL, SEQ_BAD_ADD, SEQ_REPAGE, SEQ_NOISE} seq_kind_e;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    item_t            item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    result_t          result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [REG_W-1:0] cfg_data     = '0;

    int unsigned      mismatch_count;
    int unsigned      awaited_count;

    logic [REG_W-1:0] tgt         = TARGET_RESET;
    int               items_sent  = 0;
    int               burst_left  = 0;
    int               cycle_count = 0;

    arm64_pc_relative_address_resolver_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    resolved_address_check u_resolution_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("arm64_pc_relative_address_resolver_unit_test: errors");
            $finish;
        end
    end

    // ADR / ADRP encoding, selected by the class code
    function automatic logic [WORD_W-1:0] adr_form(input logic [WORD_W-1:0] code,
                                                   input logic [REG_W-1:0] rd,
                                                   input logic [20:0] imm);
        return code | {1'b0, imm[1:0], 5'b0, imm[20:2], rd};
    endfunction

    function automatic logic [WORD_W-1:0] make_add(input logic [REG_W-1:0] rd,
                                                   input logic [REG_W-1:0] rn,
                                                   input logic sh,
                                                   input logic [11:0] imm12);
        return ADD_CODE | {9'b0, sh, imm12, rn, rd};
    endfunction

    function automatic logic [REG_W-1:0] other_reg(input logic [REG_W-1:0] t);
        return t + REG_W'($urandom_range(1, 31));
    endfunction

    function automatic logic [WORD_W-1:0] filler(input logic [REG_W-1:0] t);
        logic [WORD_W-1:0] w;
        w      = $urandom;
        w[4:0] = other_reg(t);
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] target_write(input logic [REG_W-1:0] t);
        logic [WORD_W-1:0] w;
        w      = $urandom;
        w[4:0] = t;
        return w;
    endfunction

    function automatic logic [20:0] pick_imm21();
        case ($urandom_range(0, 7))
            0: return 21'h10_0000;
            1: return 21'h0F_FFFF;
            2: return '0;
            3: return '1;
            default: return 21'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w, input logic [ADDR_W-1:0] a,
                             input logic l);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item       <= '{instruction_word: w, instruction_address: a, last_word: l};
        item_valid <= 1'b1;
        @(negedge clk);
        while (!item_ready)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
    endtask

    task automatic write_target(input logic [REG_W-1:0] r);
        cfg_data  <= r;
        cfg_valid <= 1'b1;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        tgt = r;
    endtask

    // wait out every expected result, then the pipeline depth
    task automatic drain();
        item_valid <= 1'b0;
        @(negedge clk);
        while (awaited_count != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_sequence();
        logic [WORD_W-1:0] words[$];
        logic [WORD_W-1:0] add_w;
        logic [ADDR_W-1:0] base;
        seq_kind_e         kind;
        int                r;
        r = $urandom_range(0, 11);
        kind = r < 5 ? SEQ_PAIR : r < 7 ? SEQ_ADR : r == 7 ? SEQ_CANCEL :
               r == 8 ? SEQ_BAD_ADD : r == 9 ? SEQ_REPAGE : SEQ_NOISE;
        add_w = make_add(tgt, tgt, 1'($urandom), 12'($urandom));
        repeat ($urandom_range(0, 3)) words = {words, filler(tgt)};
        case (kind)
            SEQ_PAIR:
            begin
                words = {words, adr_form(ADRP_CODE, tgt, pick_imm21())};
                repeat ($urandom_range(0, 3)) words = {words, filler(tgt)};
                words = {words, add_w};
            end
            SEQ_ADR:
                words = {words, adr_form(ADR_CODE, tgt, pick_imm21())};
            SEQ_CANCEL:
            begin
                words = {words, adr_form(ADRP_CODE, tgt, pick_imm21())};
                words = {words, target_write(tgt)};
                words = {words, add_w};
            end
            SEQ_BAD_ADD:
            begin
                words = {words, adr_form(ADRP_CODE, tgt, pick_imm21())};
                case ($urandom_range(0, 2))
                    0: words = {words, add_w ^ 32'h8000_0000};   // 32-bit ADD
                    1: words = {words, add_w | 32'h0080_0000};   // bit 23 set
                    default: words = {words, make_add(tgt, other_reg(tgt), 1'($urandom),
                                                      12'($urandom))};
                endcase
                words = {words, add_w};
            end
            SEQ_REPAGE:
            begin
                words = {words, adr_form(ADRP_CODE, tgt, pick_imm21())};
                words = {words, adr_form(ADRP_CODE, tgt, pick_imm21())};
                words = {words, add_w};
            end
            default:
                repeat ($urandom_range(1, 6))
                    words = {words, WORD_W'(($urandom_range(0, 2) == 0) ?
                                            target_write(tgt) : $urandom)};
        endcase
        repeat ($urandom_range(0, 3))
            words = {words, WORD_W'($urandom_range(0, 1) ? filler(tgt) : target_write(tgt))};
        base = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: base[63:12] = '1;
            1: base[63:12] = '0;
            default: ;
        endcase
        foreach (words[i])
            send_word(words[i],
                      ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : base + 64'(4 * i),
                      i == words.size() - 1);
    endtask

    initial
    begin : result_sink
        int cyc;
        int hold_left;
        int mode;
        int mode_left;
        cyc       = 0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == 300 || cyc == 1200)
                hold_left = 250;
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 4);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= 1'($urandom);
                    2: result_ready <= ($urandom_range(0, 3) != 0);
                    3: result_ready <= cyc[1];
                    default: result_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin
        logic [REG_W-1:0] next_tgt;
        int               budget;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // target register at its reset value
        // ADR at the top of the address space, largest forward offset: wraps
        send_word(adr_form(ADR_CODE, tgt, 21'h0F_FFFF), '1, 1'b1);
        // most negative page offset, shifted maximum imm12; trailing words ignored
        send_word(adr_form(ADRP_CODE, tgt, 21'h10_0000), 64'h0000_0000_0000_0FFF, 1'b0);
        send_word(make_add(tgt, tgt, 1'b1, 12'hFFF), 64'h1000, 1'b0);
        send_word(32'hFFFF_FFFF, '1, 1'b1);
        // ADD with bit 23 set is a plain write and cancels the page
        send_word(adr_form(ADRP_CODE, tgt, '1), 64'hFFFF_FFFF_FFFF_F000, 1'b0);
        send_word(make_add(tgt, tgt, 1'b0, 12'h001) | 32'h0080_0000, 64'h4, 1'b0);
        send_word(make_add(tgt, tgt, 1'b0, 12'h001), 64'h8, 1'b0);
        send_word(filler(tgt), 64'hC, 1'b1);
        // 32-bit ADD cancels the page
        send_word(adr_form(ADRP_CODE, tgt, 21'h00_0001), 64'h0, 1'b0);
        send_word(make_add(tgt, tgt, 1'b0, 12'h800) ^ 32'h8000_0000, 64'h4, 1'b0);
        send_word(make_add(tgt, tgt, 1'b0, 12'h800), 64'h8, 1'b1);
        // other source register cancels; a second ADRP replaces the page; hit on last word
        send_word(adr_form(ADRP_CODE, tgt, 21'h0A_BCDE), 64'h1234_5678_9ABC_DEF0, 1'b0);
        send_word(make_add(tgt, other_reg(tgt), 1'b0, 12'h123), 64'h1234_5678_9ABC_DEF4, 1'b0);
        send_word(adr_form(ADRP_CODE, tgt, 21'h0F_FFFF), 64'h8000_0000_0000_0000, 1'b0);
        send_word(adr_form(ADRP_CODE, tgt, 21'h00_0000), 64'h8000_0000_0000_2ABC, 1'b0);
        send_word(make_add(tgt, tgt, 1'b0, 12'h000), 64'h8000_0000_0000_2AC0, 1'b1);
        // ADR below zero wraps; later ADR and the last word give nothing
        send_word(adr_form(ADR_CODE, tgt, 21'h10_0000), 64'h0, 1'b0);
        send_word(adr_form(ADR_CODE, tgt, 21'h00_0004), 64'h100, 1'b0);
        send_word(32'h0000_0000, 64'h104, 1'b1);
        // all-zero word writes the register but resolves nothing
        send_word(32'h0000_0000, '0, 1'b1);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: next_tgt = 5'd31;
                1: next_tgt = 5'd0;
                3: next_tgt = 5'd1;
                4: next_tgt = 5'd30;
                default: next_tgt = REG_W'($urandom_range(0, 31));
            endcase
            write_target(next_tgt);
            budget = items_sent + PHASE_ITEMS;
            while (items_sent < budget)
                run_sequence();
            drain();
        end

        if (mismatch_count == 0 && awaited_count == 0)
            $display("arm64_pc_relative_address_resolver_unit_test: clean");
        else
            $display("arm64_pc_relative_address_resolver_unit_test: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/apr_pkg.sv
rtl/apr_resolve.sv
rtl/arm64_pc_relative_address_resolver_unit.sv
rtl/apr_checker.sv
tb/resolved_address_check.sv
tb/arm64_pc_relative_address_resolver_unit_test.sv
